>>> rtl/grain_pattern_gen_check_top_assert.svh
// ---------------------------------------------------------------------------
// grain pattern generator / checker: assertion macros
// shared property wrappers clocked on clk_i
// ---------------------------------------------------------------------------
`ifndef GRAIN_PATTERN_GEN_CHECK_TOP_ASSERT_SVH
`define GRAIN_PATTERN_GEN_CHECK_TOP_ASSERT_SVH

// checked outside reset only
`define GPGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define GPGC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/gpgc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpgc_pkg
// types, constants and helpers of the grain pattern generator / checker
// ---------------------------------------------------------------------------
package gpgc_pkg;

  localparam int unsigned OffsetBits  = 32;
  localparam int unsigned WordNumBits = 29;
  localparam int unsigned CntBits     = 4;
  localparam int unsigned AddrBits    = 4;

  localparam logic [63:0] GoldenGamma = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMulA     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB     = 64'h94d049bb133111eb;
  localparam logic [63:0] GrainMul    = 64'h00000100000001b3;
  localparam int unsigned ShiftA = 30;
  localparam int unsigned ShiftB = 27;
  localparam int unsigned ShiftC = 31;

  localparam logic [CntBits-1:0] MaxBytes = CntBits'(8);

  // register index, taken from paddr bit 3
  localparam logic RegSeed = 1'b0;

  // multiply rounds of the back end
  localparam int unsigned RoundBits = 3;
  localparam logic [RoundBits-1:0] RndGrain = 3'd0;
  localparam logic [RoundBits-1:0] RndMixA1 = 3'd1;
  localparam logic [RoundBits-1:0] RndMixA2 = 3'd2;
  localparam logic [RoundBits-1:0] RndMixB1 = 3'd3;
  localparam logic [RoundBits-1:0] RndMixB2 = 3'd4;

  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrBits = 1;
  localparam int unsigned QueueCntBits = 2;

  typedef struct packed {
    logic                   verify;
    logic [63:0]            grain;
    logic [63:0]            data;
    logic [CntBits-1:0]     cnt;
    logic                   last;
    logic [WordNumBits-1:0] pos;
    logic [OffsetBits-1:0]  start;
    logic [OffsetBits-1:0]  total;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkMul0,
    BkMul1,
    BkMul2,
    BkPost,
    BkDone
  } bk_state_e;

  function automatic logic [63:0] round_const(input logic [RoundBits-1:0] rnd);
    logic [63:0] k;
    case (rnd) inside
      RndGrain:           k = GrainMul;
      RndMixA1, RndMixB1: k = MixMulA;
      default:            k = MixMulB;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/gpgc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpgc_front
// accepts input words, tracks word position and byte offset within the grain
// ---------------------------------------------------------------------------
module gpgc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [63:0] grain_index, [127:64] data_word, [131:128] byte_count, rest zero
  input  logic [135:0]         s_axis_tdata,
  // [0] func
  input  logic [0:0]           s_axis_tuser,
  input  logic                 s_axis_tlast,
  input  gpgc_pkg::q_status_t  q_status_i,
  output logic                 push_o,
  output gpgc_pkg::item_t      item_o
);

  logic [gpgc_pkg::WordNumBits-1:0] word_q, word_d;
  logic [gpgc_pkg::OffsetBits-1:0]  total_q, total_d;
  logic [gpgc_pkg::CntBits-1:0]     cnt_raw, cnt_c;
  logic [gpgc_pkg::OffsetBits:0]    sum;
  logic [gpgc_pkg::OffsetBits-1:0]  total_sat;
  logic                             accept;

  assign s_axis_tready = !q_status_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_o        = accept;

  assign cnt_raw   = s_axis_tdata[131:128];
  assign cnt_c     = (cnt_raw > gpgc_pkg::MaxBytes) ? gpgc_pkg::MaxBytes : cnt_raw;
  assign sum       = {1'b0, total_q} + (gpgc_pkg::OffsetBits + 1)'(cnt_c);
  // byte offset saturates at all ones
  assign total_sat = sum[gpgc_pkg::OffsetBits] ? '1 : sum[gpgc_pkg::OffsetBits-1:0];

  always_comb begin
    item_o.verify = s_axis_tuser[0];
    item_o.grain  = s_axis_tdata[63:0];
    item_o.data   = s_axis_tdata[127:64];
    item_o.cnt    = cnt_c;
    item_o.last   = s_axis_tlast;
    item_o.pos    = word_q;
    item_o.start  = total_q;
    item_o.total  = total_sat;
  end

  always_comb begin
    word_d  = word_q;
    total_d = total_q;
    if (accept) begin
      if (s_axis_tlast) begin
        word_d  = '0;
        total_d = '0;
      end else begin
        word_d  = word_q + 1'b1;
        total_d = total_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q  <= '0;
      total_q <= '0;
    end else begin
      word_q  <= word_d;
      total_q <= total_d;
    end
  end

endmodule

>>> rtl/gpgc_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpgc_queue
// two-entry queue of classified words between front and back end
// ---------------------------------------------------------------------------
module gpgc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gpgc_pkg::item_t     item_i,
  input  logic                pop_i,
  output gpgc_pkg::item_t     item_o,
  output gpgc_pkg::q_status_t status_o
);

  gpgc_pkg::item_t                     mem_q [gpgc_pkg::QueueDepth];
  logic [gpgc_pkg::QueuePtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [gpgc_pkg::QueuePtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [gpgc_pkg::QueueCntBits-1:0]   count_q, count_d;

  assign status_o.full  = (count_q == gpgc_pkg::QueueCntBits'(gpgc_pkg::QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign item_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> rtl/gpgc_back.sv
`timescale 1ns / 1ps
`include "grain_pattern_gen_check_top_assert.svh"
// ---------------------------------------------------------------------------
// gpgc_back
// hashes one word at a time on a shared 32x32 multiplier, compares, reports
// ---------------------------------------------------------------------------
module gpgc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [63:0]         seed_i,
  input  gpgc_pkg::item_t     item_i,
  input  gpgc_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [63:0] pattern_word, [64] check_done, [96:65] first_bad_offset,
  // [97] grain_ok, rest zero
  output logic [103:0]        m_axis_tdata
);

  gpgc_pkg::bk_state_e                state_q, state_d;
  gpgc_pkg::item_t                    cur_q, cur_d;
  logic [gpgc_pkg::RoundBits-1:0]     round_q, round_d;
  logic [63:0]                        v_q, v_d;
  logic [63:0]                        acc_q, acc_d;
  logic                               seen_q, seen_d;
  logic [gpgc_pkg::OffsetBits-1:0]    first_q, first_d;
  logic                               out_valid_q, out_valid_d;
  logic [103:0]                       out_data_q, out_data_d;

  logic [63:0] k;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic [63:0] post_v;
  logic [63:0] byte_mask;
  logic        bad, new_seen, done_flag, ok_flag, out_load;
  logic [gpgc_pkg::OffsetBits-1:0] new_first, offset_val;

  function automatic logic [63:0] xs(input logic [63:0] x, input int unsigned sh);
    return x ^ (x >> sh);
  endfunction

  assign k = gpgc_pkg::round_const(round_q);

  // one 32x32 partial product per cycle, low 64 bits of the full product
  always_comb begin
    case (state_q)
      gpgc_pkg::BkMul1: begin
        op_a = v_q[31:0];
        op_b = k[63:32];
      end
      gpgc_pkg::BkMul2: begin
        op_a = v_q[63:32];
        op_b = k[31:0];
      end
      default: begin
        op_a = v_q[31:0];
        op_b = k[31:0];
      end
    endcase
  end

  assign prod = {32'b0, op_a} * {32'b0, op_b};

  always_comb begin
    logic [63:0] t;
    t = '0;
    case (round_q) inside
      gpgc_pkg::RndGrain: begin
        t      = (acc_q ^ seed_i) + gpgc_pkg::GoldenGamma;
        post_v = xs(t, gpgc_pkg::ShiftA);
      end
      gpgc_pkg::RndMixA1, gpgc_pkg::RndMixB1: begin
        post_v = xs(acc_q, gpgc_pkg::ShiftB);
      end
      gpgc_pkg::RndMixA2: begin
        // end of the first mix, then start of the second on the word number
        t      = (xs(acc_q, gpgc_pkg::ShiftC) ^ 64'(cur_q.pos)) + gpgc_pkg::GoldenGamma;
        post_v = xs(t, gpgc_pkg::ShiftA);
      end
      default: begin
        post_v = xs(acc_q, gpgc_pkg::ShiftC);
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[i*8 +: 8] = (gpgc_pkg::CntBits'(i) < cur_q.cnt) ? 8'hff : 8'h00;
    end
  end

  assign bad        = cur_q.verify && (((cur_q.data ^ v_q) & byte_mask) != '0);
  assign new_seen   = seen_q || bad;
  assign new_first  = (bad && !seen_q) ? cur_q.start : first_q;
  assign done_flag  = cur_q.verify && cur_q.last;
  assign ok_flag    = cur_q.verify ? !new_seen : 1'b1;
  assign offset_val = !done_flag ? '0 : (new_seen ? new_first : cur_q.total);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    round_d     = round_q;
    v_d         = v_q;
    acc_d       = acc_q;
    seen_d      = seen_q;
    first_d     = first_q;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      gpgc_pkg::BkIdle: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          cur_d   = item_i;
          v_d     = item_i.grain;
          round_d = gpgc_pkg::RndGrain;
          state_d = gpgc_pkg::BkMul0;
        end
      end
      gpgc_pkg::BkMul0: begin
        acc_d   = prod;
        state_d = gpgc_pkg::BkMul1;
      end
      gpgc_pkg::BkMul1: begin
        acc_d   = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
        state_d = gpgc_pkg::BkMul2;
      end
      gpgc_pkg::BkMul2: begin
        acc_d   = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
        state_d = gpgc_pkg::BkPost;
      end
      gpgc_pkg::BkPost: begin
        v_d = post_v;
        if (round_q == gpgc_pkg::RndMixB2) begin
          state_d = gpgc_pkg::BkDone;
        end else begin
          round_d = round_q + 1'b1;
          state_d = gpgc_pkg::BkMul0;
        end
      end
      gpgc_pkg::BkDone: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load   = 1'b1;
          out_data_d = {6'b0, ok_flag, 32'(offset_val), done_flag, v_q};
          if (cur_q.last) begin
            seen_d  = 1'b0;
            first_d = '0;
          end else begin
            seen_d  = new_seen;
            first_d = new_first;
          end
          state_d = gpgc_pkg::BkIdle;
        end
      end
      default: begin
        state_d = gpgc_pkg::BkIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    v_q        <= v_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gpgc_pkg::BkIdle;
      round_q     <= '0;
      seen_q      <= 1'b0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      seen_q      <= seen_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  `GPGC_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> state_q == gpgc_pkg::BkIdle, "back end not idle in reset")
  `GPGC_ASSERT(a_pop_when_idle, pop_o |-> state_q == gpgc_pkg::BkIdle && !q_status_i.empty, "pop outside idle")
  `GPGC_ASSERT(a_load_slot_free, out_load |-> !out_valid_q || m_axis_tready, "result overwrote a waiting word")
  `GPGC_ASSERT(a_grain_clears, out_load && cur_q.last |=> !seen_q && first_q == '0, "mismatch state kept across grains")
  `GPGC_ASSERT(a_round_range, state_q != gpgc_pkg::BkIdle |-> round_q <= gpgc_pkg::RndMixB2, "round counter out of range")

endmodule

>>> rtl/grain_pattern_gen_check_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grain_pattern_gen_check_top
// splitmix64 position pattern generator and checker for streamed grains
// ---------------------------------------------------------------------------
// input words arrive on the s_axis channel: tuser selects generate (0) or
// verify (1), tlast closes the grain, tdata carries grain index, data word
// and valid byte count. every word gives one result word on m_axis with the
// pattern word, the check status and, on a verified last word, the byte
// offset of the first bad word or the grain size.
// the seed is to be written over the apb port only while the block is idle;
// the block does not enforce this. the back end runs five 64-bit products,
// each as three passes through one 32x32 multiplier plus a mixing step,
// and finishes one word before it takes the next from the queue.
// the front keeps the position counters and takes up to two words ahead into
// its queue; a stalled m_axis holds the result register, the back end then
// waits, and the queue fills before s_axis_tready falls.
// reset clears the seed, position and mismatch state and empties the queue.
// ---------------------------------------------------------------------------
module grain_pattern_gen_check_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [63:0] grain_index, [127:64] data_word, [131:128] byte_count, rest zero
  input  logic [135:0]                 s_axis_tdata,
  // [0] func
  input  logic [0:0]                   s_axis_tuser,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [63:0] pattern_word, [64] check_done, [96:65] first_bad_offset,
  // [97] grain_ok, rest zero
  output logic [103:0]                 m_axis_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gpgc_pkg::AddrBits-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  logic [63:0]         seed_q, seed_d;
  logic                push;
  logic                pop;
  gpgc_pkg::item_t     front_item;
  gpgc_pkg::item_t     queue_item;
  gpgc_pkg::q_status_t q_status;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == gpgc_pkg::RegSeed) ? seed_q : '0;

  always_comb begin
    seed_d = seed_q;
    if (psel && penable && pwrite && pready && paddr[3] == gpgc_pkg::RegSeed) begin
      seed_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else begin
      seed_q <= seed_d;
    end
  end

  gpgc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_status_i    (q_status),
    .push_o        (push),
    .item_o        (front_item)
  );

  gpgc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (queue_item),
    .status_o (q_status)
  );

  gpgc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_i        (seed_q),
    .item_i        (queue_item),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> sim/grain_pattern_gen_check_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grain_pattern_gen_check_top_test
// self-checking bench for the grain pattern generator / checker
// ---------------------------------------------------------------------------
// a short table of hand-picked words runs first, with the check fields typed
// in where they are plain to see, then random grains under several seeds.
// every accepted word is run through a splitmix64 pattern predictor held in
// the bench; result words are compared field by field in arrival order.
// the source idles in random bursts in all phases but the third and last, the sink in all but the fourth and last.
// ---------------------------------------------------------------------------
module grain_pattern_gen_check_top_test;

  localparam logic FuncGen    = 1'b0;
  localparam logic FuncVerify = 1'b1;
  localparam logic [gpgc_pkg::AddrBits-1:0] AddrSeed = '0;

  localparam logic [63:0] MixGamma  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixK1     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixK2     = 64'h94d049bb133111eb;
  localparam logic [63:0] GrainStep = 64'h00000100000001b3;

  typedef struct {
    logic        func;
    logic [63:0] grain;
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
  } grain_word_t;

  typedef struct packed {
    logic [63:0] pattern;
    logic        done;
    logic [31:0] offset;
    logic        ok;
  } grain_result_t;

  // one line of the hand-picked table; data is an xor mask on the pattern
  // word when on_pattern is set
  typedef struct {
    logic        func;
    logic [63:0] grain;
    logic        on_pattern;
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
    logic        typed;
    logic        done;
    logic [31:0] offset;
    logic        ok;
  } table_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [135:0]   s_axis_tdata;
  logic [0:0]     s_axis_tuser;
  logic           s_axis_tlast;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [103:0]   m_axis_tdata;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [gpgc_pkg::AddrBits-1:0] paddr;
  logic [63:0]    pwdata;
  logic [63:0]    prdata;
  logic           pready;

  // predictor state
  logic [63:0] seed_now;
  logic [28:0] word_pos;
  logic [31:0] bytes_seen;
  logic        bad_seen;
  logic [31:0] bad_offset;

  grain_result_t pending_results[$];
  table_row_t    bench_rows[$];
  int            fail_count;
  bit            src_idle;
  bit            sink_idle;
  int            sink_hold = 0;

  grain_pattern_gen_check_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [63:0] splitmix_fold(input logic [63:0] v);
    logic [63:0] z;
    z = v + MixGamma;
    z = (z ^ (z >> 30)) * MixK1;
    z = (z ^ (z >> 27)) * MixK2;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [63:0] grain_pattern(input logic [63:0] seed,
                                                input logic [63:0] grain,
                                                input logic [28:0] pos);
    return splitmix_fold(splitmix_fold(seed ^ (grain * GrainStep)) ^ {35'd0, pos});
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // advances the position and mismatch state by one accepted word
  function automatic grain_result_t predict_grain_result(input grain_word_t w);
    grain_result_t r;
    logic [3:0]    n;
    logic [63:0]   mask;
    logic [31:0]   start;
    logic [32:0]   sum;
    n = (w.cnt > 4'd8) ? 4'd8 : w.cnt;
    r.pattern = grain_pattern(seed_now, w.grain, word_pos);
    r.done    = 1'b0;
    r.offset  = '0;
    r.ok      = 1'b1;
    start     = bytes_seen;
    if (w.func == FuncVerify) begin
      mask = (n == 4'd8) ? '1 : ((64'd1 << {n, 3'b000}) - 64'd1);
      if ((((w.data ^ r.pattern) & mask) != '0) && !bad_seen) begin
        bad_seen   = 1'b1;
        bad_offset = start;
      end
    end
    sum = {1'b0, bytes_seen} + {29'd0, n};
    bytes_seen = sum[32] ? '1 : sum[31:0];
    word_pos   = word_pos + 29'd1;
    if (w.func == FuncVerify) begin
      r.ok = !bad_seen;
      if (w.last) begin
        r.done   = 1'b1;
        r.offset = bad_seen ? bad_offset : bytes_seen;
      end
    end
    if (w.last) begin
      word_pos   = '0;
      bytes_seen = '0;
      bad_seen   = 1'b0;
      bad_offset = '0;
    end
    return r;
  endfunction

  function automatic table_row_t row(input logic func, input logic [63:0] grain,
                                     input logic on_pattern, input logic [63:0] data,
                                     input logic [3:0] cnt, input logic last,
                                     input logic typed, input logic done,
                                     input logic [31:0] offset, input logic ok);
    table_row_t t;
    t.func = func; t.grain = grain; t.on_pattern = on_pattern; t.data = data;
    t.cnt = cnt; t.last = last; t.typed = typed; t.done = done;
    t.offset = offset; t.ok = ok;
    return t;
  endfunction

  // sends one word; valid stays high into the next word unless a gap comes
  task automatic send_word(input grain_word_t w, input bit typed,
                           input grain_result_t typed_res);
    grain_result_t r;
    int            gap;
    if (src_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, w.cnt, w.data, w.grain};
    s_axis_tuser  <= w.func;
    s_axis_tlast  <= w.last;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_grain_result(w);
    if (typed) begin
      r.done   = typed_res.done;
      r.offset = typed_res.offset;
      r.ok     = typed_res.ok;
    end
    pending_results.push_back(r);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrSeed;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seed_now = value;
  endtask

  task automatic read_seed();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrSeed;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== seed_now) begin
      $display("%0t seed read: expected %h got %h", $time, seed_now, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_table();
    grain_word_t   w;
    grain_result_t t;
    foreach (bench_rows[i]) begin
      w.func  = bench_rows[i].func;
      w.grain = bench_rows[i].grain;
      w.cnt   = bench_rows[i].cnt;
      w.last  = bench_rows[i].last;
      w.data  = bench_rows[i].data;
      if (bench_rows[i].on_pattern) begin
        w.data = grain_pattern(seed_now, w.grain, word_pos) ^ bench_rows[i].data;
      end
      t.pattern = '0;
      t.done    = bench_rows[i].done;
      t.offset  = bench_rows[i].offset;
      t.ok      = bench_rows[i].ok;
      send_word(w, bench_rows[i].typed, t);
    end
  endtask

  // mostly well-formed grains with random content, some noise words
  task automatic run_grains(input int n_words);
    grain_word_t   w;
    grain_result_t none;
    int            sent;
    int            len;
    int            mode;
    bit            corrupt;
    logic          fixed_func;
    none = '0;
    sent = 0;
    while (sent < n_words) begin
      len     = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
                                             : $urandom_range(1, 12);
      mode    = $urandom_range(0, 9);
      corrupt = ($urandom_range(0, 2) == 0);
      fixed_func = (mode < 6) ? FuncVerify : FuncGen;
      case ($urandom_range(0, 7))
        0:       w.grain = '0;
        1:       w.grain = '1;
        default: w.grain = rand64();
      endcase
      for (int k = 0; k < len; k++) begin
        w.func = (mode == 9) ? logic'($urandom_range(0, 1)) : fixed_func;
        w.last = (k == len - 1);
        w.cnt  = w.last ? 4'($urandom_range(1, 8)) : 4'd8;
        if ($urandom_range(0, 15) == 0) w.cnt = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 31) == 0) w.grain = rand64();
        if (w.func == FuncVerify && $urandom_range(0, 19) != 0) begin
          w.data = grain_pattern(seed_now, w.grain, word_pos);
          if (corrupt && $urandom_range(0, 3) == 0) w.data ^= rand64();
        end else begin
          w.data = rand64();
        end
        send_word(w, 1'b0, none);
        sent++;
      end
    end
  endtask

  // result side: random stall bursts
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 7) == 0) begin
      sink_hold <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    grain_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result word: expected none got %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[63:0] !== want.pattern) begin
          $display("%0t pattern_word: expected %h got %h", $time, want.pattern,
                   m_axis_tdata[63:0]);
          fail_count++;
        end
        if (m_axis_tdata[64] !== want.done) begin
          $display("%0t check_done: expected %b got %b", $time, want.done, m_axis_tdata[64]);
          fail_count++;
        end
        if (m_axis_tdata[96:65] !== want.offset) begin
          $display("%0t first_bad_offset: expected %0d got %0d", $time, want.offset,
                   m_axis_tdata[96:65]);
          fail_count++;
        end
        if (m_axis_tdata[97] !== want.ok) begin
          $display("%0t grain_ok: expected %b got %b", $time, want.ok, m_axis_tdata[97]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    fail_count = 0;
    src_idle   = 1'b1;
    sink_idle  = 1'b1;
    seed_now   = '0;
    word_pos   = '0;
    bytes_seen = '0;
    bad_seen   = 1'b0;
    bad_offset = '0;

    // typed fields: check_done, first_bad_offset, grain_ok
    bench_rows.push_back(row(FuncGen, 64'd0, 0, 64'd0, 4'd8, 0, 1, 0, 0, 1));
    bench_rows.push_back(row(FuncGen, '1, 0, '1, 4'd8, 1, 1, 0, 0, 1));
    bench_rows.push_back(row(FuncVerify, 64'd5, 1, 64'd0, 4'd8, 0, 1, 0, 0, 1));
    bench_rows.push_back(row(FuncVerify, 64'd5, 1, 64'd0, 4'd8, 1, 1, 1, 16, 1));
    bench_rows.push_back(row(FuncVerify, 64'd7, 1, 64'h8000_0000_0000_0000, 4'd8, 0,
                             1, 0, 0, 0));
    bench_rows.push_back(row(FuncVerify, 64'd7, 1, 64'd0, 4'd8, 1, 1, 1, 0, 0));
    // no bytes valid: anything matches and nothing adds to the size
    bench_rows.push_back(row(FuncVerify, 64'd9, 0, '1, 4'd0, 0, 1, 0, 0, 1));
    // short last word, junk above the valid bytes
    bench_rows.push_back(row(FuncVerify, 64'd9, 1, 64'hffff_ffff_ff00_0000, 4'd3, 1,
                             1, 1, 3, 1));
    // counts above eight count as eight
    bench_rows.push_back(row(FuncVerify, 64'd11, 1, 64'h8000_0000_0000_0000, 4'd15, 0,
                             1, 0, 0, 0));
    bench_rows.push_back(row(FuncVerify, 64'd11, 1, 64'd0, 4'd9, 1, 1, 1, 0, 0));
    // short word in the middle of a grain
    bench_rows.push_back(row(FuncVerify, 64'd12, 1, 64'd0, 4'd1, 0, 1, 0, 0, 1));
    bench_rows.push_back(row(FuncVerify, 64'd12, 1, 64'd1, 4'd8, 1, 1, 1, 1, 0));
    // generate and verify mixed in one grain
    bench_rows.push_back(row(FuncGen, 64'd20, 0, 64'd0, 4'd8, 0, 1, 0, 0, 1));
    bench_rows.push_back(row(FuncVerify, 64'd20, 1, 64'h100, 4'd2, 0, 1, 0, 0, 0));
    bench_rows.push_back(row(FuncGen, 64'd20, 0, '1, 4'd8, 0, 1, 0, 0, 1));
    bench_rows.push_back(row(FuncVerify, 64'd20, 1, 64'd0, 4'd8, 1, 1, 1, 8, 0));
    // grain index changes within a grain
    bench_rows.push_back(row(FuncVerify, 64'd30, 1, 64'd0, 4'd8, 0, 1, 0, 0, 1));
    bench_rows.push_back(row(FuncVerify, 64'd31, 1, 64'd0, 4'd8, 1, 1, 1, 16, 1));
    bench_rows.push_back(row(FuncVerify, '1, 0, '1, 4'd8, 1, 0, 0, 0, 0));
    bench_rows.push_back(row(FuncVerify, 64'h5555_5555_5555_5555, 0, 64'd0, 4'd8, 1,
                             0, 0, 0, 0));
    bench_rows.push_back(row(FuncVerify, 64'd40, 1, 64'd0, 4'd0, 1, 1, 1, 0, 1));
    bench_rows.push_back(row(FuncGen, 64'haaaa_aaaa_aaaa_aaaa, 0, 64'd0, 4'd4, 1,
                             1, 0, 0, 1));
    bench_rows.push_back(row(FuncVerify, 64'd50, 1, 64'hff00_0000_0000_0000, 4'd7, 1,
                             1, 1, 7, 1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    read_seed();
    run_table();
    wait_drained();

    write_seed('1);
    read_seed();
    run_grains(250);
    wait_drained();

    write_seed(rand64());
    read_seed();
    src_idle = 1'b0;
    run_grains(250);
    wait_drained();

    write_seed('0);
    read_seed();
    src_idle  = 1'b1;
    sink_idle = 1'b0;
    run_grains(150);
    wait_drained();

    // last stretch at full rate on both sides
    write_seed(rand64());
    read_seed();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_grains(250);
    wait_drained();

    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
